// ===== src/ccsod_pkg.sv =====
// ccsod_pkg: shared constants, action codes and control structs of the shape drawer
// used by every module of the block but ccsod_ram; depends on nothing
`default_nettype none
package ccsod_pkg;

  localparam int COLS_DEF     = 85;
  localparam int ROWS_DEF     = 28;
  localparam int MAX_SIZE_DEF = 20;

  localparam int IW    = 8;   // iterator width, signed
  localparam int RAW_W = 11;  // unwrapped coordinate width, signed
  localparam int CNTW  = 11;
  localparam int CHW   = 8;

  localparam logic [CHW-1:0] SPACE_CHAR    = 8'd32;
  localparam logic [CHW-1:0] DRAW_CHAR_RST = 8'd42;

  localparam logic signed [IW-1:0] S_ZERO = IW'(0);
  localparam logic signed [IW-1:0] S_ONE  = IW'(1);
  localparam logic signed [IW-1:0] S_TWO  = IW'(2);
  localparam logic signed [RAW_W-1:0] R_ONE = RAW_W'(1);

  typedef enum logic [2:0] {
    ACT_TRI = 3'd0,
    ACT_SQR = 3'd1,
    ACT_CIR = 3'd2,
    ACT_LIN = 3'd3,
    ACT_RHO = 3'd4,
    ACT_HEX = 3'd5,
    ACT_RD  = 3'd6,
    ACT_WR  = 3'd7
  } ccsod_act_e;

  localparam logic [2:0] ORI_UP    = 3'd0;
  localparam logic [2:0] ORI_DOWN  = 3'd1;
  localparam logic [2:0] ORI_RIGHT = 3'd2;
  localparam logic [2:0] ORI_LEFT  = 3'd3;
  localparam logic [2:0] ORI_VERT  = 3'd4;
  localparam logic [2:0] ORI_HORZ  = 3'd5;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic init;
    logic run;
    logic push;
  } ccsod_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic run_done;
  } ccsod_sts_t;

endpackage
`default_nettype wire

// ===== src/ccsod_ram.sv =====
// ccsod_ram: generic one-write one-read RAM with registered read data
// no dependencies
`default_nettype none
module ccsod_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 64
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [W-1:0]             wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [W-1:0]            rdata_o
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/ccsod_ctrl.sv =====
// ccsod_ctrl: controller state machine of the shape drawer
// depends on ccsod_pkg; drives the datapath through ccsod_cmd_t
`default_nettype none
module ccsod_ctrl import ccsod_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  input  ccsod_sts_t  sts_i,
  output ccsod_cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_INIT  = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_q, state_d;
  logic       oval_q, oval_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    oval_d  = oval_q;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_INIT;
        end
      end
      ST_INIT: begin
        cmd_o.init = 1'b1;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.run_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          oval_d     = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      oval_q  <= oval_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;

endmodule
`default_nettype wire

// ===== src/ccsod_dp.sv =====
// ccsod_dp: shape cell generator, coordinate wrap, frame store and result registers
// depends on ccsod_pkg and ccsod_ram; commanded by ccsod_ctrl
`default_nettype none
module ccsod_dp import ccsod_pkg::*; #(
  parameter int COLS     = COLS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  ccsod_cmd_t      cmd_i,
  output ccsod_sts_t      sts_o,
  input  wire             cfg_valid_i,
  input  wire [CHW-1:0]   draw_char_i,
  input  wire [2:0]       action_i,
  input  wire [6:0]       x_i,
  input  wire [4:0]       y_i,
  input  wire [4:0]       size_i,
  input  wire [2:0]       orient_i,
  input  wire [CHW-1:0]   write_char_i,
  output logic [CHW-1:0]  read_char_o,
  output logic [CNTW-1:0] cells_written_o
);

  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam logic signed [RAW_W-1:0] R_COLS = RAW_W'(COLS);
  localparam logic signed [RAW_W-1:0] R_ROWS = RAW_W'(ROWS);

  function automatic logic signed [IW-1:0] f_abs(input logic signed [IW-1:0] v);
    f_abs = (v < S_ZERO) ? -v : v;
  endfunction

  function automatic logic signed [IW-1:0] f_blo(input ccsod_act_e act,
                                                 input logic signed [IW-1:0] a,
                                                 input logic signed [IW-1:0] ns,
                                                 input logic signed [IW-1:0] hs);
    case (act)
      ACT_RHO: f_blo = -hs;
      ACT_HEX: f_blo = f_abs(a) - ns;
      default: f_blo = S_ZERO;
    endcase
  endfunction

  function automatic logic signed [IW-1:0] f_bhi(input ccsod_act_e act, input logic ph,
                                                 input logic signed [IW-1:0] a,
                                                 input logic signed [IW-1:0] ns,
                                                 input logic signed [IW-1:0] hs);
    case (act)
      ACT_SQR: f_bhi = ns - S_ONE;
      ACT_TRI: f_bhi = ph ? (ns + ns - S_TWO) : S_ONE;
      ACT_CIR: f_bhi = ns + ns;
      ACT_RHO: f_bhi = hs;
      ACT_HEX: f_bhi = ns - f_abs(a);
      default: f_bhi = S_ZERO;
    endcase
  endfunction

  // command registers
  ccsod_act_e          act_q;
  logic [6:0]          x_q;
  logic [4:0]          y_q;
  logic [NW-1:0]       n_q;
  logic [2:0]          o_q;
  logic [CHW-1:0]      wch_q;
  logic [CHW-1:0]      dch_q;

  // iterator and pending cell
  logic signed [IW-1:0]    a_q, b_q;
  logic                    ph_q, gdone_q, pend_q, rdw_q;
  logic signed [RAW_W-1:0] col_q, row_q;
  logic [CHW-1:0]          ch_q;
  logic [CNTW-1:0]         cnt_q;
  logic [CHW-1:0]          rd_q;
  logic [AW-1:0]           clr_q;
  logic [CHW-1:0]          ord_q;
  logic [CNTW-1:0]         ocnt_q;

  logic signed [IW-1:0]    ns, hs, a_lo, a_hi, b_hi, dcc, drr;
  logic signed [RAW_W-1:0] xs, ys, ax, bx, nx, hx, kx, cx, cy;
  logic signed [2*IW:0]    d2, outer, inner;
  logic [CHW-1:0]          ch;
  logic                    emit, brd, on, empty;
  logic                    col_ok, row_ok, fixed, is_rd;
  logic [AW-1:0]           addr;
  logic [CHW-1:0]          ram_rdata;
  logic                    ram_we, ram_re;

  assign ns = signed'(IW'(n_q));
  assign hs = ns >>> 1;
  assign xs = signed'(RAW_W'(x_q));
  assign ys = signed'(RAW_W'(y_q));
  assign ax = RAW_W'(a_q);
  assign bx = RAW_W'(b_q);
  assign nx = RAW_W'(ns);
  assign hx = RAW_W'(hs);
  assign kx = ph_q ? bx : ax;
  assign dcc = b_q - ns;
  assign drr = a_q - ns;
  assign d2    = (2*IW+1)'(dcc * dcc) + (2*IW+1)'(drr * drr);
  assign outer = (2*IW+1)'(ns * ns);
  assign inner = (2*IW+1)'((ns - S_ONE) * (ns - S_ONE));

  // cell at the current iterator position
  always_comb begin
    emit = 1'b1;
    cx   = xs;
    cy   = ys;
    ch   = dch_q;
    brd  = (a_q == S_ZERO) || (b_q == S_ZERO) || (a_q == ns - S_ONE) || (b_q == ns - S_ONE);
    on   = 1'b0;
    case (act_q)
      ACT_SQR: begin
        ch = brd ? dch_q : SPACE_CHAR;
        case (o_q)
          ORI_UP:    begin cx = xs + bx + bx; cy = ys + ax; end
          ORI_DOWN:  begin cx = xs + bx + bx; cy = ys - ax; end
          ORI_RIGHT: begin cx = xs + ax + ax; cy = ys + bx; end
          default:   begin cx = xs - ax - ax; cy = ys + bx; end
        endcase
      end
      ACT_TRI: begin
        if (ph_q) begin
          case (o_q)
            ORI_UP:    begin cx = xs - nx + kx; cy = ys + nx - R_ONE; end
            ORI_DOWN:  begin cx = xs - nx + kx; cy = ys - nx + R_ONE; end
            ORI_RIGHT: begin cx = xs + nx - R_ONE; cy = ys - nx + kx; end
            default:   begin cx = xs - nx + R_ONE; cy = ys - nx + kx; end
          endcase
        end else if (b_q == S_ZERO) begin
          case (o_q)
            ORI_UP:    begin cx = xs - kx; cy = ys + kx; end
            ORI_DOWN:  begin cx = xs - kx; cy = ys - kx; end
            ORI_RIGHT: begin cx = xs + kx; cy = ys + kx; end
            default:   begin cx = xs - kx; cy = ys + kx; end
          endcase
        end else begin
          emit = (a_q > S_ZERO) && ((o_q == ORI_UP) || (o_q == ORI_DOWN) || (a_q < ns - S_ONE));
          case (o_q)
            ORI_UP:    begin cx = xs + kx; cy = ys + kx; end
            ORI_DOWN:  begin cx = xs + kx; cy = ys - kx; end
            ORI_RIGHT: begin cx = xs + kx; cy = ys - kx; end
            default:   begin cx = xs - kx; cy = ys - kx; end
          endcase
        end
      end
      ACT_CIR: begin
        on = (d2 <= outer) && ((ns == S_ZERO) || (d2 >= inner));
        ch = on ? dch_q : SPACE_CHAR;
        cx = xs + bx + bx;
        cy = ys + ax;
      end
      ACT_LIN: begin
        case (o_q)
          ORI_UP:    cy = ys - ax;
          ORI_DOWN:  cy = ys + ax;
          ORI_RIGHT: cx = xs + ax;
          default:   cx = xs - ax;
        endcase
      end
      ACT_RHO: begin
        on = (f_abs(a_q) + f_abs(b_q) == hs);
        ch = on ? dch_q : SPACE_CHAR;
        cx = xs + bx + bx + hx + hx;
        cy = (o_q == ORI_UP) ? (ys + ax) : (ys + ax + hx);
      end
      ACT_HEX: begin
        emit = (b_q == f_blo(act_q, a_q, ns, hs)) || (b_q == f_bhi(act_q, ph_q, a_q, ns, hs))
            || (a_q == -hs) || (a_q == hs);
        cx = xs + bx + bx;
        cy = (o_q == ORI_VERT) ? (ys - ax + hx) : (ys + ax + ax);
      end
      ACT_WR:  ch = wch_q;
      default: ch = wch_q;
    endcase
  end

  // iteration bounds and empty commands
  always_comb begin
    a_lo  = S_ZERO;
    a_hi  = S_ZERO;
    empty = 1'b0;
    case (act_q)
      ACT_SQR, ACT_LIN: begin
        a_hi  = ns - S_ONE;
        empty = (n_q == '0) || (o_q > ORI_LEFT);
      end
      ACT_TRI: begin
        a_hi  = ph_q ? S_ZERO : ns - S_ONE;
        empty = (n_q == '0) || (o_q > ORI_LEFT);
      end
      ACT_CIR: a_hi = ns + ns;
      ACT_RHO: begin
        a_lo  = -hs;
        a_hi  = hs;
        empty = (o_q > ORI_DOWN);
      end
      ACT_HEX: begin
        a_lo  = -hs;
        a_hi  = hs;
        empty = (o_q != ORI_VERT) && (o_q != ORI_HORZ);
      end
      default: a_hi = S_ZERO;
    endcase
  end

  assign b_hi   = f_bhi(act_q, ph_q, a_q, ns, hs);
  assign col_ok = (col_q >= RAW_W'(0)) && (col_q < R_COLS);
  assign row_ok = (row_q >= RAW_W'(0)) && (row_q < R_ROWS);
  assign fixed  = pend_q && col_ok && row_ok;
  assign is_rd  = (act_q == ACT_RD);
  assign addr   = AW'(AW'(row_q[RW-1:0]) * AW'(COLS)) + AW'(col_q[CW-1:0]);
  assign ram_we = cmd_i.clr_step || (cmd_i.run && fixed && !is_rd);
  assign ram_re = cmd_i.run && fixed && is_rd;

  ccsod_ram #(.W(CHW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_i.clr_step ? clr_q : addr),
    .wdata_i (cmd_i.clr_step ? SPACE_CHAR : ch_q),
    .re_i    (ram_re),
    .raddr_i (addr),
    .rdata_o (ram_rdata)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dch_q   <= DRAW_CHAR_RST;
      clr_q   <= '0;
      gdone_q <= 1'b1;
      pend_q  <= 1'b0;
      rdw_q   <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        dch_q <= draw_char_i;
      end
      if (cmd_i.clr_step) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.init) begin
        gdone_q <= empty;
        pend_q  <= 1'b0;
        rdw_q   <= 1'b0;
      end else if (cmd_i.run) begin
        if (rdw_q) begin
          rdw_q <= 1'b0;
        end
        if (!pend_q || fixed) begin
          if (fixed && is_rd) begin
            rdw_q <= 1'b1;
          end
          pend_q <= !gdone_q && emit;
          if (!gdone_q && b_q == b_hi && a_q == a_hi && !(act_q == ACT_TRI && !ph_q)) begin
            gdone_q <= 1'b1;
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= ccsod_act_e'(action_i);
      x_q   <= x_i;
      y_q   <= y_i;
      n_q   <= (int'(size_i) > MAX_SIZE) ? NW'(MAX_SIZE) : NW'(size_i);
      o_q   <= orient_i;
      wch_q <= write_char_i;
    end
    if (cmd_i.init) begin
      a_q   <= a_lo;
      b_q   <= f_blo(act_q, a_lo, ns, hs);
      ph_q  <= 1'b0;
      cnt_q <= '0;
      rd_q  <= '0;
    end else if (cmd_i.run) begin
      if (rdw_q) begin
        rd_q <= ram_rdata;
      end
      if (pend_q && !fixed) begin
        if (col_q < RAW_W'(0)) begin
          col_q <= col_q + R_COLS;
        end else if (!col_ok) begin
          col_q <= col_q - R_COLS;
        end
        if (row_q < RAW_W'(0)) begin
          row_q <= row_q + R_ROWS;
        end else if (!row_ok) begin
          row_q <= row_q - R_ROWS;
        end
      end else begin
        if (fixed && !is_rd) begin
          cnt_q <= cnt_q + CNTW'(1);
        end
        col_q <= cx;
        row_q <= cy;
        ch_q  <= ch;
        if (!gdone_q) begin
          if (b_q != b_hi) begin
            b_q <= b_q + S_ONE;
          end else if (a_q != a_hi) begin
            a_q <= a_q + S_ONE;
            b_q <= f_blo(act_q, a_q + S_ONE, ns, hs);
          end else if (act_q == ACT_TRI && !ph_q) begin
            ph_q <= 1'b1;
            a_q  <= S_ZERO;
            b_q  <= S_ZERO;
          end
        end
      end
    end
    if (cmd_i.push) begin
      ord_q  <= rd_q;
      ocnt_q <= cnt_q;
    end
  end

  assign sts_o.clr_done   = (clr_q == AW'(DEPTH - 1));
  assign sts_o.run_done   = gdone_q && !pend_q && !rdw_q;
  assign read_char_o      = ord_q;
  assign cells_written_o  = ocnt_q;

endmodule
`default_nettype wire

// ===== src/char_cell_shape_outline_drawer_top.sv =====
// char_cell_shape_outline_drawer_top: character frame store shape drawer
// command flow: load and setup, then the visited shape positions in turn, with wrap corrections
// for each off-screen cell and a wait for the read data on a read, then the result push
// throughput: one command at a time, the next word is taken while the result word waits
// reset: a clearing pass writes space to all ROWS*COLS cells before the first word is taken;
// draw_char resets to 42; depends on ccsod_pkg, ccsod_ctrl, ccsod_dp
`default_nettype none
module char_cell_shape_outline_drawer_top import ccsod_pkg::*; #(
  parameter int COLS     = COLS_DEF,
  parameter int ROWS     = ROWS_DEF,
  parameter int MAX_SIZE = MAX_SIZE_DEF
) (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire [CHW-1:0]   draw_char_i,
  input  wire             in_valid_i,
  output logic            in_ready_o,
  input  wire [2:0]       action_i,
  input  wire [6:0]       x_i,
  input  wire [4:0]       y_i,
  input  wire [4:0]       size_i,
  input  wire [2:0]       orient_i,
  input  wire [CHW-1:0]   write_char_i,
  output logic            out_valid_o,
  input  wire             out_ready_i,
  output logic [CHW-1:0]  read_char_o,
  output logic [CNTW-1:0] cells_written_o
);

  ccsod_cmd_t cmd;
  ccsod_sts_t sts;

  assign cfg_ready_o = 1'b1;

  ccsod_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ccsod_dp #(.COLS(COLS), .ROWS(ROWS), .MAX_SIZE(MAX_SIZE)) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .draw_char_i     (draw_char_i),
    .action_i        (action_i),
    .x_i             (x_i),
    .y_i             (y_i),
    .size_i          (size_i),
    .orient_i        (orient_i),
    .write_char_i    (write_char_i),
    .read_char_o     (read_char_o),
    .cells_written_o (cells_written_o)
  );

endmodule
`default_nettype wire

// ===== src/ccsod_chk.sv =====
// ccsod_chk: port-level checks of the shape drawer, bound to the top level
// depends on ccsod_pkg
`default_nettype none
module ccsod_chk import ccsod_pkg::*; (
  input wire            clk_i,
  input wire            rst_ni,
  input wire            cfg_valid_i,
  input wire            cfg_ready_o,
  input wire [CHW-1:0]  draw_char_i,
  input wire            in_valid_i,
  input wire            in_ready_o,
  input wire [2:0]      action_i,
  input wire [6:0]      x_i,
  input wire [4:0]      y_i,
  input wire [4:0]      size_i,
  input wire [2:0]      orient_i,
  input wire [CHW-1:0]  write_char_i,
  input wire            out_valid_o,
  input wire            out_ready_i,
  input wire [CHW-1:0]  read_char_o,
  input wire [CNTW-1:0] cells_written_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cells_written_o)
      && $stable(read_char_o))
    else $error("result word dropped or changed while stalled");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second word taken while a command is running");

  a_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cells_written_o != '0 |-> read_char_o == '0)
    else $error("read data on a word that wrote cells");

  a_cfg_rdy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config word refused");

endmodule

bind char_cell_shape_outline_drawer_top ccsod_chk u_chk (.*);
`default_nettype wire
